// ===== rtl/core/byte_ring_fifo_with_search_core_assert.svh =====
// Assertion helpers used by the ring FIFO RTL (included by brfs_ctrl).
`ifndef BYTE_RING_FIFO_WITH_SEARCH_CORE_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_SEARCH_CORE_ASSERT_SVH

// Condition must hold on every clock edge out of reset.
`define BRFS_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define BRFS_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BRFS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/brfs_pkg.sv =====
`default_nettype none

package brfs_pkg;

  localparam int unsigned MAX_DEPTH_LOG2 = 8;
  localparam int unsigned PTR_W          = MAX_DEPTH_LOG2;
  localparam int unsigned DEPTH          = 1 << MAX_DEPTH_LOG2;
  localparam int unsigned CAP_W          = 4;
  localparam int unsigned APB_AW         = 3;
  localparam int unsigned APB_DW         = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_DEPTH_LOG2);

  // Register index, taken from paddr[2] (registers sit on 4-byte steps).
  localparam logic REG_CAPACITY_LOG2 = 1'b0;

  typedef logic [7:0]       byte_t;
  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_PUSH   = 3'd1,
    CMD_POP    = 3'd2,
    CMD_PEEK   = 3'd3,
    CMD_SKIP   = 3'd4,
    CMD_SEARCH = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH
  } state_e;

  typedef struct packed {
    logic  we;
    ptr_t  waddr;
    byte_t wdata;
    logic  re;
    ptr_t  raddr;
  } mem_req_t;

  typedef struct packed {
    byte_t data_out;
    byte_t match_position;
    logic  match_found;
    byte_t count;
    byte_t free_space;
    logic  is_empty;
    logic  is_full;
    logic  error;
  } result_t;

  // Ring index mask for a capacity code; code clamped to 1..MAX_DEPTH_LOG2.
  function automatic ptr_t mask_of(logic [CAP_W-1:0] k);
    logic [CAP_W-1:0] eff;
    ptr_t             ones;
    eff  = k;
    ones = '1;
    if (eff == '0) begin
      eff = CAP_W'(1);
    end
    if (eff > CAP_W'(MAX_DEPTH_LOG2)) begin
      eff = CAP_W'(MAX_DEPTH_LOG2);
    end
    return ones >> (CAP_W'(PTR_W) - eff);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/brfs_ring_mem.sv =====
`default_nettype none

// Byte store, one write and one read port, registered read data.
module brfs_ring_mem import brfs_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output byte_t    rdata_o
);

  byte_t mem_q [DEPTH];
  byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/brfs_ctrl.sv =====
`default_nettype none

`include "byte_ring_fifo_with_search_core_assert.svh"

// Pointer state, command sequencer and search walker.
module brfs_ctrl import brfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_clear_i,
  input  ptr_t       mask_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] command_i,
  input  byte_t      data_in_i,
  input  byte_t      offset_i,
  input  logic       out_free_i,
  output logic       res_load_o,
  output result_t    res_o,
  output mem_req_t   mem_req_o,
  input  byte_t      mem_rdata_i
);

  state_e state_q, state_d;
  ptr_t   head_q, head_d;
  ptr_t   tail_q, tail_d;
  ptr_t   idx_q, idx_d;
  byte_t  key_q, key_d;

  ptr_t   cnt_q;
  logic   empty_q;
  logic   full_q;
  logic   accept;
  logic   hit;
  logic   last;
  cmd_e   cmd;

  byte_t  dout;
  ptr_t   mpos;
  logic   found;
  logic   err;
  ptr_t   cnt_n;

  assign cmd     = cmd_e'(command_i);
  assign cnt_q   = (tail_q - head_q) & mask_i;
  assign empty_q = (head_q == tail_q);
  assign full_q  = (((tail_q + ptr_t'(1)) & mask_i) == head_q);

  assign in_ready_o = (state_q == ST_IDLE) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;

  // search: data in hand belongs to entry idx_q
  assign hit  = (mem_rdata_i == key_q);
  assign last = ((idx_q + ptr_t'(1)) == cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_POP && !empty_q) begin
            state_d = ST_READ;
          end else if (cmd == CMD_PEEK) begin
            state_d = ST_READ;
          end else if (cmd == CMD_SEARCH && cnt_q != '0) begin
            state_d = ST_SEARCH;
          end
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_SEARCH: begin
        if (hit || last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and memory requests
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    idx_d      = idx_q;
    key_d      = key_q;
    mem_req_o  = '0;
    res_load_o = 1'b0;
    dout       = '0;
    mpos       = '0;
    found      = 1'b0;
    err        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_CLEAR: begin
              head_d     = '0;
              tail_d     = '0;
              res_load_o = 1'b1;
            end
            CMD_PUSH: begin
              res_load_o = 1'b1;
              if (full_q) begin
                err = 1'b1;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = tail_q;
                mem_req_o.wdata = data_in_i;
                tail_d          = (tail_q + ptr_t'(1)) & mask_i;
              end
            end
            CMD_POP: begin
              if (empty_q) begin
                err        = 1'b1;
                res_load_o = 1'b1;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = head_q;
                head_d          = (head_q + ptr_t'(1)) & mask_i;
              end
            end
            CMD_PEEK: begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = (head_q + ptr_t'(offset_i)) & mask_i;
            end
            CMD_SKIP: begin
              res_load_o = 1'b1;
              if (ptr_t'(offset_i) <= cnt_q) begin
                head_d = (head_q + ptr_t'(offset_i)) & mask_i;
              end
            end
            CMD_SEARCH: begin
              if (cnt_q == '0) begin
                res_load_o = 1'b1;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = head_q;
                idx_d           = '0;
                key_d           = data_in_i;
              end
            end
            default: begin
              res_load_o = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_load_o = 1'b1;
        dout       = mem_rdata_i;
      end
      ST_SEARCH: begin
        if (hit) begin
          res_load_o = 1'b1;
          found      = 1'b1;
          mpos       = idx_q;
        end else if (last) begin
          res_load_o = 1'b1;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = (head_q + idx_q + ptr_t'(1)) & mask_i;
          idx_d           = idx_q + ptr_t'(1);
        end
      end
      default: begin
      end
    endcase
    if (cfg_clear_i) begin
      head_d = '0;
      tail_d = '0;
    end
  end

  // status as it stands after the command
  always_comb begin
    cnt_n                = (tail_d - head_d) & mask_i;
    res_o.data_out       = dout;
    res_o.match_position = byte_t'(mpos);
    res_o.match_found    = found;
    res_o.count          = byte_t'(cnt_n);
    res_o.free_space     = byte_t'(mask_i - cnt_n);
    res_o.is_empty       = (tail_d == head_d);
    res_o.is_full        = (((tail_d + ptr_t'(1)) & mask_i) == head_d);
    res_o.error          = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
  end

  `BRFS_ASSERT_ALWAYS(a_ptr_in_ring, clk_i, rst_ni,
    ((head_q & ~mask_i) == '0) && ((tail_q & ~mask_i) == '0),
    "pointer outside ring")
  `BRFS_ASSERT_IMPLIES(a_search_idx, clk_i, rst_ni, state_q == ST_SEARCH,
    idx_q < cnt_q, "search index past count")
  `BRFS_ASSERT_IMPLIES(a_no_overwrite, clk_i, rst_ni, res_load_o, out_free_i,
    "result loaded into occupied output register")
  `BRFS_ASSERT_NEXT(a_pop_reads, clk_i, rst_ni, accept && cmd == CMD_POP && !empty_q,
    state_q == ST_READ, "pop did not wait for memory data")

endmodule

`default_nettype wire

// ===== rtl/core/byte_ring_fifo_with_search_core.sv =====
`default_nettype none

// Byte ring FIFO with search. The ring has 2^capacity_log2 slots (codes
// clamped to 1..8) and holds one byte fewer than that. Each input word is one
// command (clear, push, pop, peek, skip, search; codes 6 and 7 only report
// status) and yields exactly one result word carrying the popped/peeked
// byte, search outcome, count, free space, empty, full and error flags.
// Timing is set by the single registered read port of the ring memory:
// clear, push, skip and unused codes need no read and can be issued back to
// back while results are taken; pop and peek wait in the read state for the
// data; search compares one entry per cycle from the head until a hit or
// the count (an empty ring answers with no read). A result sits in the
// output register until taken; the next word is accepted in the same cycle
// the current result leaves. No memory clearing pass after reset is needed:
// only slots between head and tail are ever trusted. Writing capacity_log2
// (APB offset 0x0) also empties the ring; write it only while idle.
module byte_ring_fifo_with_search_core import brfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command words
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        command_i,
  input  logic [7:0]        data_in_i,
  input  logic [7:0]        offset_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        data_out_o,
  output logic [7:0]        match_position_o,
  output logic              match_found_o,
  output logic [7:0]        count_o,
  output logic [7:0]        free_space_o,
  output logic              is_empty_o,
  output logic              is_full_o,
  output logic              error_o,
  // APB config
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CAP_W-1:0] cap_q, cap_d;
  logic             cfg_we;
  ptr_t             mask;

  logic             out_valid_q, out_valid_d;
  result_t          res_q;
  result_t          res;
  logic             res_load;
  logic             out_free;

  mem_req_t         mem_req;
  byte_t            mem_rdata;

  // ---- config register ----
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_CAPACITY_LOG2);
  assign cap_d  = cfg_we ? pwdata[CAP_W-1:0] : cap_q;
  assign prdata = (paddr[2] == REG_CAPACITY_LOG2) ? APB_DW'(cap_q) : '0;
  assign mask   = mask_of(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  // ---- output register: frees up the same cycle the word is taken ----
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_out_o       = res_q.data_out;
  assign match_position_o = res_q.match_position;
  assign match_found_o    = res_q.match_found;
  assign count_o          = res_q.count;
  assign free_space_o     = res_q.free_space;
  assign is_empty_o       = res_q.is_empty;
  assign is_full_o        = res_q.is_full;
  assign error_o          = res_q.error;

  // ---- sequencer ----
  // Pushes write before any later read is issued, so reads never race a
  // write to the same slot.
  brfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_clear_i (cfg_we),
    .mask_i      (mask),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .data_in_i   (data_in_i),
    .offset_i    (offset_i),
    .out_free_i  (out_free),
    .res_load_o  (res_load),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // ---- ring storage ----
  brfs_ring_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== tb/byte_ring_fifo_with_search_core_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the byte ring FIFO with search.
module byte_ring_fifo_with_search_core_tb import brfs_pkg::*; ();

  localparam int          CLK_PERIOD  = 10;
  localparam int          RESET_CYCLES = 7;
  // Slowest legal run: ~1850 words, each with the longest sender gap, a full
  // 255-compare search and the longest receiver stall, plus the long holds.
  // CYCLE_LIMIT allows several times that.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          MAX_GAP     = 18;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_TAIL  = 8;

  // Command codes the block treats as "status only".
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam logic [APB_AW-1:0] CAP_ADDR = {REG_CAPACITY_LOG2, 2'b00};

  // Two copies of the ring shadow: one used while planning stimulus (so we
  // never aim a peek at a slot that was never written), one advanced when
  // the block actually accepts a word.
  localparam int PLAN_VIEW  = 0;
  localparam int CHECK_VIEW = 1;

  typedef struct packed {
    logic [2:0] cmd;
    byte_t      din;
    byte_t      off;
  } cmd_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [2:0]          command_i   = CMD_CLEAR;
  logic [7:0]          data_in_i   = '0;
  logic [7:0]          offset_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          data_out_o;
  logic [7:0]          match_position_o;
  logic                match_found_o;
  logic [7:0]          count_o;
  logic [7:0]          free_space_o;
  logic                is_empty_o;
  logic                is_full_o;
  logic                error_o;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [APB_AW-1:0]   paddr   = '0;
  logic [APB_DW-1:0]   pwdata  = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  byte_t      ring_mem  [2][DEPTH];
  bit         ring_wr   [2][DEPTH];
  ptr_t       ring_head [2];
  ptr_t       ring_tail [2];
  logic [3:0] ring_cap  [2];

  cmd_word_t pending_words[$];
  result_t   due_results[$];

  int unsigned words_issued    = 0;
  int unsigned words_accepted  = 0;
  int unsigned results_taken   = 0;
  int unsigned fails           = 0;
  int unsigned cycle_count     = 0;
  int unsigned capacity_writes = 0;
  int unsigned refused_seen    = 0;
  int unsigned search_hits     = 0;
  int unsigned full_seen       = 0;
  int unsigned empty_seen      = 0;

  int src_max_gap   = MAX_GAP;
  int snk_max_gap   = MAX_GAP;
  int src_wait      = 0;
  int snk_wait      = 0;
  int hold_requests = 0;
  int hold_served   = 0;

  byte_ring_fifo_with_search_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .data_in_i        (data_in_i),
    .offset_i         (offset_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_out_o       (data_out_o),
    .match_position_o (match_position_o),
    .match_found_o    (match_found_o),
    .count_o          (count_o),
    .free_space_o     (free_space_o),
    .is_empty_o       (is_empty_o),
    .is_full_o        (is_full_o),
    .error_o          (error_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Index mask for the current capacity code; 0 behaves as 1 and anything
  // above the build depth behaves as the build depth.
  function automatic ptr_t ring_mask(int v);
    int k;
    k = int'(ring_cap[v]);
    if (k < 1) begin
      k = 1;
    end
    if (k > MAX_DEPTH_LOG2) begin
      k = MAX_DEPTH_LOG2;
    end
    return ptr_t'((1 << k) - 1);
  endfunction

  // Executes one command word on a shadow ring and returns the status word
  // the block must answer with.
  function automatic result_t exec_command(int v, logic [2:0] cmd, byte_t din, byte_t off);
    result_t r;
    ptr_t    m;
    ptr_t    h;
    ptr_t    t;
    ptr_t    held;
    int      i;
    m    = ring_mask(v);
    h    = ring_head[v];
    t    = ring_tail[v];
    held = (t - h) & m;
    r    = '0;
    case (cmd)
      CMD_CLEAR: begin
        h = '0;
        t = '0;
      end
      CMD_PUSH: begin
        // refused on a full ring, nothing moves
        if (((t + ptr_t'(1)) & m) == h) begin
          r.error = 1'b1;
        end else begin
          ring_mem[v][t] = din;
          ring_wr[v][t]  = 1'b1;
          t = (t + ptr_t'(1)) & m;
        end
      end
      CMD_POP: begin
        if (t == h) begin
          r.error = 1'b1;
        end else begin
          r.data_out = ring_mem[v][h];
          h = (h + ptr_t'(1)) & m;
        end
      end
      CMD_PEEK: begin
        // past the count the slot is still read as it stands
        r.data_out = ring_mem[v][ptr_t'((h + off) & m)];
      end
      CMD_SKIP: begin
        if (off <= held) begin
          h = (h + off) & m;
        end
      end
      CMD_SEARCH: begin
        for (i = 0; i < held; i++) begin
          if (!r.match_found && ring_mem[v][ptr_t'((h + i) & m)] == din) begin
            r.match_found    = 1'b1;
            r.match_position = byte_t'(i);
          end
        end
      end
      default: begin
      end
    endcase
    ring_head[v]  = h;
    ring_tail[v]  = t;
    held          = (t - h) & m;
    r.count       = held;
    r.free_space  = m - held;
    r.is_empty    = (t == h);
    r.is_full     = (((t + ptr_t'(1)) & m) == h);
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      fails++;
    end
  endfunction

  // Plans a word against the planning shadow and hands it to the sender.
  task automatic queue_word(logic [2:0] cmd, byte_t din, byte_t off);
    void'(exec_command(PLAN_VIEW, cmd, din, off));
    pending_words.push_back(cmd_word_t'{cmd, din, off});
  endtask

  task automatic add_random_word(int push_pct);
    logic [2:0] cmd;
    byte_t      din;
    byte_t      off;
    ptr_t       m;
    ptr_t       h;
    ptr_t       held;
    int         roll;
    int         tries;
    m    = ring_mask(PLAN_VIEW);
    h    = ring_head[PLAN_VIEW];
    held = (ring_tail[PLAN_VIEW] - h) & m;
    din  = byte_t'($urandom_range(0, 255));
    off  = byte_t'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      cmd = CMD_CLEAR;
    end else if (roll < 4) begin
      cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end else if (roll < 4 + push_pct) begin
      cmd = CMD_PUSH;
    end else begin
      case ($urandom_range(0, 3))
        0:       cmd = CMD_POP;
        1:       cmd = CMD_PEEK;
        2:       cmd = CMD_SKIP;
        default: cmd = CMD_SEARCH;
      endcase
    end
    case (cmd)
      CMD_PEEK: begin
        // aim only at slots that hold a written byte
        for (tries = 0; tries < 8 && !ring_wr[PLAN_VIEW][ptr_t'((h + off) & m)]; tries++) begin
          off = byte_t'($urandom_range(0, 255));
        end
        if (!ring_wr[PLAN_VIEW][ptr_t'((h + off) & m)]) begin
          if (held != 0) begin
            off = byte_t'($urandom_range(0, held - 1));
          end else begin
            cmd = CMD_PUSH;
          end
        end
      end
      CMD_SKIP: begin
        if ($urandom_range(0, 9) < 7) begin
          off = byte_t'($urandom_range(0, held));
        end
      end
      CMD_SEARCH: begin
        // mostly look for something that is actually in the ring
        if (held != 0 && $urandom_range(0, 9) < 6) begin
          din = ring_mem[PLAN_VIEW][ptr_t'((h + $urandom_range(0, held - 1)) & m)];
        end
      end
      default: begin
      end
    endcase
    queue_word(cmd, din, off);
  endtask

  // Returns once every planned word has been answered, then idles through
  // the DRAIN_TAIL settle time.
  task automatic wait_drained();
    while (pending_words.size() != 0 || results_taken != words_issued) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  // APB write of capacity_log2; the ring empties with it.
  task automatic write_capacity(logic [3:0] code);
    int v;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= APB_DW'(code);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    for (v = 0; v < 2; v++) begin
      ring_cap[v]  = code;
      ring_head[v] = '0;
      ring_tail[v] = '0;
    end
    capacity_writes++;
  endtask

  task automatic run_phase(logic [3:0] cap_code, int words, int push_pct,
                           int src_gap, int snk_gap, bit long_hold);
    wait_drained();
    write_capacity(cap_code);
    src_max_gap = src_gap;
    snk_max_gap = snk_gap;
    // receiver goes deaf for a while; sender keeps offering, block backs up
    if (long_hold) begin
      hold_requests++;
    end
    repeat (words) add_random_word(push_pct);
  endtask

  // Sender: one word at a time from pending_words, with a random gap drawn
  // per word. Valid and payload hold until the block takes the word.
  always @(posedge clk_i) begin : sender
    cmd_word_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        due_results.push_back(exec_command(CHECK_VIEW, command_i, data_in_i, offset_i));
        words_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (src_wait > 0) begin
          src_wait--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          command_i  <= w.cmd;
          data_in_i  <= w.din;
          offset_i   <= w.off;
          in_valid_i <= 1'b1;
          words_issued++;
          src_wait = $urandom_range(0, src_max_gap);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every status word against the oldest one due, then
  // stalls for a drawn number of cycles. A hold request stalls it long.
  always @(posedge clk_i) begin : receiver
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_taken++;
        if (due_results.size() == 0) begin
          $error("status word with no command outstanding");
          fails++;
        end else begin
          want = due_results.pop_front();
          check_field("data_out",       want.data_out,       data_out_o);
          check_field("match_position", want.match_position, match_position_o);
          check_field("match_found",    8'(want.match_found), 8'(match_found_o));
          check_field("count",          want.count,          count_o);
          check_field("free_space",     want.free_space,     free_space_o);
          check_field("is_empty",       8'(want.is_empty),   8'(is_empty_o));
          check_field("is_full",        8'(want.is_full),    8'(is_full_o));
          check_field("error",          8'(want.error),      8'(error_o));
          refused_seen += want.error;
          search_hits  += want.match_found;
          full_seen    += want.is_full;
          empty_seen   += want.is_empty;
        end
        snk_wait = $urandom_range(0, snk_max_gap);
      end else if (snk_wait > 0) begin
        snk_wait--;
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        snk_wait    = HOLD_CYCLES;
      end
      out_ready_i <= (snk_wait == 0);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int v;
    for (v = 0; v < 2; v++) begin
      ring_head[v] = '0;
      ring_tail[v] = '0;
      ring_cap[v]  = CAP_RESET;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 4-slot ring (3 usable) so full/empty/wrap come quickly.
    write_capacity(4'd2);
    queue_word(CMD_POP,    8'h00, 8'h00);  // pop on empty is refused
    queue_word(CMD_SEARCH, 8'h00, 8'h00);  // search an empty ring
    queue_word(CMD_SKIP,   8'h00, 8'h01);  // skip past count: no-op
    queue_word(CMD_PUSH,   8'h00, 8'h00);
    queue_word(CMD_PUSH,   8'hFF, 8'h00);
    queue_word(CMD_PUSH,   8'hA5, 8'h00);  // now full
    queue_word(CMD_PUSH,   8'h5A, 8'h00);  // push on full is refused
    queue_word(CMD_PEEK,   8'h00, 8'h00);
    queue_word(CMD_PEEK,   8'h00, 8'hFE);  // large offset wraps onto slot 2
    queue_word(CMD_POP,    8'h00, 8'h00);
    queue_word(CMD_PUSH,   8'h5A, 8'h00);  // tail wraps to 0, full again
    queue_word(CMD_PEEK,   8'h00, 8'hFF);  // beyond count, stale slot 0
    queue_word(CMD_SEARCH, 8'hA5, 8'h00);  // hit at position 1
    queue_word(CMD_SEARCH, 8'h77, 8'h00);  // miss
    queue_word(CMD_SKIP,   8'h00, 8'hFF);  // beyond count: no-op
    queue_word(CMD_SKIP,   8'h00, 8'h02);
    queue_word(CMD_SPARE_LO, 8'h00, 8'h00);
    queue_word(CMD_SPARE_HI, 8'hFF, 8'hFF);
    queue_word(CMD_POP,    8'h00, 8'h00);  // head wraps, ring empty
    queue_word(CMD_POP,    8'h00, 8'h00);
    queue_word(CMD_PUSH,   8'h3C, 8'h00);
    queue_word(CMD_CLEAR,  8'h00, 8'h00);
    queue_word(CMD_PEEK,   8'h00, 8'h00);  // peek on empty ring
    queue_word(CMD_SKIP,   8'h00, 8'h00);  // skip 0 on empty
    queue_word(CMD_SEARCH, 8'h3C, 8'h00);

    // Random: capacity codes cover both clamp ends and every bit of the
    // register; gap settings give busy, idle and lopsided stretches.
    run_phase(4'd8,  500, 60, 0,       MAX_GAP, 1'b1);
    run_phase(4'd15, 250, 35, MAX_GAP, MAX_GAP, 1'b0);
    run_phase(4'd0,  150, 40, MAX_GAP, 0,       1'b0);
    run_phase(4'd1,  150, 35, 0,       0,       1'b0);
    run_phase(4'd3,  250, 40, 0,       MAX_GAP, 1'b1);
    run_phase(4'd5,  300, 45, MAX_GAP, MAX_GAP, 1'b0);
    run_phase(4'd4,  225, 50, 9,       9,       1'b0);
    wait_drained();

    if (due_results.size() != 0) begin
      $error("%0d status words never arrived", due_results.size());
      fails++;
    end
    $display("Run covered %0d command words over %0d capacity settings in %0d cycles.",
             words_accepted, capacity_writes, cycle_count);
    $display("Seen: %0d refused push/pop, %0d search hits, %0d full and %0d empty statuses.",
             refused_seen, search_hits, full_seen, empty_seen);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
